// File: sv/sws_pkg.sv
// Shared types and constants for the stable weight sorter.
// Holds the item structs, the cell entry and the command passed to the cells.
// Depends on nothing.
package sws_pkg;

  localparam int ENTRIES = 256;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_TAKE   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] weight;
  } req_item_t;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [31:0] sorted_weight;
    logic [1:0]  status;
    logic        last;
  } rsp_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] weight;
    logic [7:0]  symbol;
  } entry_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_TAKE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t    op;
    entry_t fresh;
  } cell_cmd_t;

endpackage

// File: sv/sws_cell.sv
// One sorter cell: holds a single entry and shifts with its neighbors.
// Depends on sws_pkg.
module sws_cell (
  input  logic               clk,
  input  logic               rst,
  input  sws_pkg::cell_cmd_t cmd,
  input  sws_pkg::entry_t    prev_ent,
  input  logic               prev_place,
  input  sws_pkg::entry_t    next_ent,
  output sws_pkg::entry_t    ent,
  output logic               place
);
  import sws_pkg::*;

  entry_t ent_next;

  // The new weight lands at or before this cell when the cell is empty or larger.
  assign place = !ent.valid || (ent.weight > cmd.fresh.weight);

  always_comb begin
    ent_next = ent;
    unique case (cmd.op)
      OP_INSERT: begin
        if (place) begin
          ent_next = prev_place ? prev_ent : cmd.fresh;
        end
      end
      OP_TAKE:  ent_next = next_ent;
      OP_CLEAR: ent_next.valid = 1'b0;
      default:  ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.weight <= ent_next.weight;
    ent.symbol <= ent_next.symbol;
  end

endmodule

// File: sv/stable_weight_sorter.sv
// Top level of the stable weight sorter: a row of sws_cell instances kept in
// ascending weight order, plus the item handshake and the result register.
// Depends on sws_pkg and sws_cell.
//
// Usage: each request item carries func and weight. Insert places the weight
// after every held entry of equal or smaller weight and numbers it by arrival
// order. Take returns and removes the smallest entry, with last set when the
// store becomes empty. Clear empties the store and restarts numbering.
// Every request item produces exactly one response item.
// The response is registered and valid in the cycle after acceptance. The block
// takes one item per cycle unless a response stalls: each cell compares the new
// weight with its entry in parallel, and the row shifts one place in that edge.
// A response waits in its output register while rsp_ready is low; req_ready
// is high whenever that register is empty or is being emptied, so a stalled
// receiver stops new requests after one item.
// Synchronous reset empties every cell, clears the arrival counter and drops
// any pending response. No clearing pass is needed.
module stable_weight_sorter (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sws_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sws_pkg::rsp_item_t rsp
);
  import sws_pkg::*;

  entry_t    ent [ENTRIES];
  logic      place [ENTRIES];
  cell_cmd_t cmd;
  logic      accept;
  logic      full;
  logic      empty;
  logic [8:0] arrival;
  rsp_item_t rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = ent[ENTRIES-1].valid;
  assign empty     = !ent[0].valid;

  always_comb begin
    cmd.op           = OP_NONE;
    cmd.fresh.valid  = 1'b1;
    cmd.fresh.weight = req.weight;
    cmd.fresh.symbol = arrival[7:0];
    rsp_next         = '0;
    if (accept) begin
      priority if (req.func == FUNC_INSERT) begin
        if (full) begin
          rsp_next.status = STATUS_FULL;
        end else begin
          cmd.op = OP_INSERT;
        end
      end else if (req.func == FUNC_TAKE) begin
        if (empty) begin
          rsp_next.status = STATUS_EMPTY;
        end else begin
          cmd.op                 = OP_TAKE;
          rsp_next.symbol        = ent[0].symbol;
          rsp_next.sorted_weight = ent[0].weight;
          rsp_next.last          = !ent[1].valid;
        end
      end else if (req.func == FUNC_CLEAR) begin
        cmd.op = OP_CLEAR;
      end else begin
        cmd.op = OP_NONE;
      end
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t prev_ent;
    logic   prev_place;
    entry_t next_ent;

    if (i == 0) begin : g_head
      assign prev_ent   = '0;
      assign prev_place = 1'b0;
    end else begin : g_body
      assign prev_ent   = ent[i-1];
      assign prev_place = place[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_link
      assign next_ent = ent[i+1];
    end

    sws_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .prev_ent   (prev_ent),
      .prev_place (prev_place),
      .next_ent   (next_ent),
      .ent        (ent[i]),
      .place      (place[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_INSERT) begin
        arrival <= arrival + 9'd1;
      end else if (cmd.op == OP_CLEAR) begin
        arrival <= '0;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && req.func == FUNC_CLEAR |=> !ent[0].valid && !ent[ENTRIES-1].valid)
    else $error("store not empty after clear");

  a_packed_row: assert property (@(posedge clk) disable iff (rst)
    ent[ENTRIES-1].valid |-> ent[0].valid)
    else $error("cell row has a hole at its head");

  a_insert_lands: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_INSERT |=> ent[0].valid && rsp_valid && rsp.status == STATUS_DONE)
    else $error("accepted insert did not land in the row");
`endif

endmodule

// File: verif/sws_checker.sv
// Scoreboard for the stable weight sorter: watches both item channels, keeps
// its own sorted store to predict every response item and compares them.
// Depends on sws_pkg.
module sws_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  sws_pkg::req_item_t req,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  sws_pkg::rsp_item_t rsp,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  logic [31:0] held_weight [ENTRIES];
  logic [7:0]  held_symbol [ENTRIES];
  int unsigned held_n;
  logic [8:0]  next_arrival;
  rsp_item_t   pending_answers [$];

  initial begin
    errors = 0;
    pending = 0;
    held_n = 0;
    next_arrival = '0;
  end

  function automatic rsp_item_t sort_step(input req_item_t item);
    rsp_item_t   answer;
    int unsigned pos;
    int unsigned k;
    answer = '0;
    answer.status = STATUS_DONE;
    case (item.func)
      FUNC_INSERT: begin
        if (held_n >= ENTRIES) begin
          answer.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < held_n && held_weight[pos] <= item.weight) pos++;
          for (k = held_n; k > pos; k--) begin
            held_weight[k] = held_weight[k - 1];
            held_symbol[k] = held_symbol[k - 1];
          end
          held_weight[pos] = item.weight;
          held_symbol[pos] = next_arrival[7:0];
          held_n++;
          next_arrival = next_arrival + 9'd1;
        end
      end
      FUNC_TAKE: begin
        if (held_n == 0) begin
          answer.status = STATUS_EMPTY;
        end else begin
          answer.symbol = held_symbol[0];
          answer.sorted_weight = held_weight[0];
          for (k = 1; k < held_n; k++) begin
            held_weight[k - 1] = held_weight[k];
            held_symbol[k - 1] = held_symbol[k];
          end
          held_n--;
          answer.last = (held_n == 0);
        end
      end
      FUNC_CLEAR: begin
        held_n = 0;
        next_arrival = '0;
      end
      default: begin
      end
    endcase
    return answer;
  endfunction

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      held_n = 0;
      next_arrival = '0;
      pending_answers.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_answers.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: response item with none outstanding: sym %0d wt %h st %0d last %0b",
                     $realtime, rsp.symbol, rsp.sorted_weight, rsp.status, rsp.last);
        end else begin
          want = pending_answers.pop_front();
          if (rsp.symbol !== want.symbol || rsp.sorted_weight !== want.sorted_weight ||
              rsp.status !== want.status || rsp.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected sym %0d wt %h st %0d last %0b, got sym %0d wt %h st %0d last %0b",
                       $realtime, want.symbol, want.sorted_weight, want.status, want.last,
                       rsp.symbol, rsp.sorted_weight, rsp.status, rsp.last);
          end
        end
      end
      if (req_valid && req_ready) pending_answers.push_back(sort_step(req));
    end
    pending = pending_answers.size();
  end

endmodule

// File: verif/tb_stable_weight_sorter.sv
// Testbench top for the stable weight sorter: drives request items under
// several pacing phases, stalls the response side and gives the verdict.
// Depends on sws_pkg, sws_checker and stable_weight_sorter.
module tb_stable_weight_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b1;
  rsp_item_t rsp;
  int        errors;
  int        pending;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        items_sent = 0;

  stable_weight_sorter uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  sws_checker checker_i (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic [1:0] code, input logic [31:0] w);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: code, weight: w};
    do @(posedge clk); while (!req_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(3))
      0, 1: return $urandom_range(7);
      2: return $urandom();
      default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  task automatic random_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned run;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      run = $urandom_range(24, 1);
      if (run > count - sent) run = count - sent;
      if (pick < 45) begin
        repeat (run) send_item(FUNC_INSERT, pick_weight());
        sent += run;
      end else if (pick < 85) begin
        repeat (run) send_item(FUNC_TAKE, $urandom());
        sent += run;
      end else if (pick < 92) begin
        send_item(FUNC_UNUSED, $urandom());
        sent++;
      end else if (pick < 96) begin
        send_item(FUNC_CLEAR, $urandom());
        sent++;
      end else begin
        send_item(FUNC_INSERT, $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(FUNC_TAKE, 32'hFFFF_FFFF);
    send_item(FUNC_INSERT, 32'h0000_0005);
    send_item(FUNC_INSERT, 32'hFFFF_FFFF);
    send_item(FUNC_INSERT, 32'h0000_0000);
    send_item(FUNC_INSERT, 32'h0000_0005);
    send_item(FUNC_INSERT, 32'h0000_0000);
    send_item(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_item(FUNC_UNUSED, 32'h0);
    repeat (5) send_item(FUNC_TAKE, 32'h0);
    send_item(FUNC_TAKE, 32'h5555_AAAA);
    send_item(FUNC_INSERT, 32'hAAAA_5555);
    send_item(FUNC_INSERT, 32'h5555_AAAA);
    send_item(FUNC_CLEAR, 32'hFFFF_FFFF);
    send_item(FUNC_TAKE, 32'h0);
    send_item(FUNC_INSERT, 32'h0000_0009);
    send_item(FUNC_TAKE, 32'h0);
    drain();

    // Fill past capacity, reuse symbol numbers, then empty past the bottom.
    send_item(FUNC_CLEAR, $urandom());
    repeat (ENTRIES + 2) send_item(FUNC_INSERT, pick_weight());
    repeat (20) send_item(FUNC_TAKE, $urandom());
    repeat (21) send_item(FUNC_INSERT, pick_weight());
    repeat (ENTRIES + 2) send_item(FUNC_TAKE, $urandom());
    random_traffic(20);
    drain();

    idle_pct = 71;
    stall_pct = 0;
    random_traffic(40);
    drain();

    idle_pct = 0;
    stall_pct = 71;
    random_traffic(40);
    drain();

    idle_pct = 26;
    stall_pct = 26;
    random_traffic(40);
    drain();

    idle_pct = 0;
    stall_pct = 0;
    random_traffic(40);
    drain();

    repeat (5) @(negedge clk);
    $display("Sent %0d request items over four pacing phases, including a fill past capacity,",
             items_sent);
    $display("reused symbol numbers, takes from an empty store and clears.");
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
